[design/tgr_pkg.sv]
`timescale 1ns / 1ps

package tgr_pkg;

   localparam int TimeWidth  = 32;
   localparam int CfgWidth   = 16;
   localparam int SpeedWidth = 17;
   localparam int NumLanes   = 2;
   localparam int ReqWidth   = 40;
   localparam int RspWidth   = 24;

   localparam logic [CfgWidth-1:0] DebounceReset = 16'd20;
   localparam logic [CfgWidth-1:0] SpeedReset    = 16'd3000;

   typedef enum logic {
      REG_DEBOUNCE_MS  = 1'b0,
      REG_TRAVEL_SPEED = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic stable;
      logic hit;
   } lane_status_type;

   typedef struct packed {
      logic                         motor_run;
      logic                         toward_limit_two;
      logic signed [SpeedWidth-1:0] speed_cmd;
      logic                         limit_one_stable;
      logic                         limit_two_stable;
   } result_type;

endpackage

[design/tgr_lane.sv]
`timescale 1ns / 1ps

module tgr_lane
   import tgr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  logic                 raw,
   input  logic [TimeWidth-1:0] now,
   input  logic [CfgWidth-1:0]  debounce_ms,
   output lane_status_type      status
);

   logic                 last_raw_ff, last_raw_in;
   logic                 stable_ff, stable_in;
   logic                 event_ff, event_in;
   logic [TimeWidth-1:0] change_time_ff, change_time_in;
   logic [TimeWidth-1:0] elapsed;
   logic                 event_mid;

   always_comb begin
      elapsed        = now - change_time_ff;
      last_raw_in    = last_raw_ff;
      change_time_in = change_time_ff;
      stable_in      = stable_ff;
      event_mid      = event_ff;
      if (raw != last_raw_ff) begin
         last_raw_in    = raw;
         change_time_in = now;
      end else if (elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, debounce_ms}
                   && stable_ff != last_raw_ff) begin
         stable_in = last_raw_ff;
         if (!last_raw_ff) begin
            event_mid = 1'b0;
         end
      end
      status.stable = stable_in;
      status.hit    = stable_in && !event_mid;
      event_in      = event_mid || status.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         event_ff       <= 1'b0;
         change_time_ff <= '0;
      end else if (update) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         event_ff       <= event_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

[design/tgr_merge.sv]
`timescale 1ns / 1ps

module tgr_merge
   import tgr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  lane_status_type     lane_one,
   input  lane_status_type     lane_two,
   input  logic                motion_on,
   input  logic                stop_request,
   input  logic [CfgWidth-1:0] travel_speed,
   output result_type          result
);

   logic            direction_ff, direction_in;
   logic            run;
   logic [SpeedWidth-1:0] magnitude;
   result_type      result_ff, result_in;

   always_comb begin
      magnitude    = {1'b0, travel_speed};
      direction_in = direction_ff;
      if (lane_two.hit) begin
         direction_in = 1'b0;
      end else if (lane_one.hit) begin
         direction_in = 1'b1;
      end
      run = motion_on && !stop_request && !(lane_one.stable && lane_two.stable);
      result_in.motor_run        = run;
      result_in.toward_limit_two = direction_in;
      if (!run) begin
         result_in.speed_cmd = '0;
      end else if (direction_in) begin
         result_in.speed_cmd = magnitude;
      end else begin
         result_in.speed_cmd = {SpeedWidth{1'b0}} - magnitude;
      end
      result_in.limit_one_stable = lane_one.stable;
      result_in.limit_two_stable = lane_two.stable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b1;
      end else if (update) begin
         direction_ff <= direction_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[design/traverse_guide_reversal_core.sv]
`timescale 1ns / 1ps

// traverse guide reversal core
// req channel: one update per transfer carrying both raw limit levels, the
// millisecond tick, enable and alarm. rsp channel: one result per update
// with run, direction, signed speed and both debounced limit levels.
// csr port: csr_we writes csr_wdata to register csr_addr (0 debounce_ms,
// 1 travel_speed) on the same edge; write only while idle.
// two debounce lanes run side by side, one per switch, and a merge stage
// resolves reversal (limit two wins) and the speed command.
// the result is registered and valid in the cycle after the req transfer.
// throughput: one update per cycle while the output is not stalled; the single
// output register takes a new result in the same cycle the old one transfers.
// stall: while rsp_tvalid is high and rsp_tready low, req_tready is low and
// the result holds.
// reset: synchronous, clears both lanes, sets direction toward limit two,
// restores debounce_ms 20 and travel_speed 3000, and empties the output.

module traverse_guide_reversal_core
   import tgr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // limit_one_active, limit_two_active, time_ms[31:0], motion_on, stop_request
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // motor_run, toward_limit_two, speed_cmd[16:0], limit_one_stable, limit_two_stable
   output logic [RspWidth-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [CfgWidth-1:0] csr_wdata
);

   logic [CfgWidth-1:0] debounce_ff;
   logic [CfgWidth-1:0] speed_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   lane_status_type     lane_one, lane_two;
   result_type          result;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DebounceReset;
         speed_ff    <= SpeedReset;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_DEBOUNCE_MS:  debounce_ff <= csr_wdata;
            REG_TRAVEL_SPEED: speed_ff    <= csr_wdata;
            default:          ;
         endcase
      end
   end

   tgr_lane u_lane_one (
      .clock       (clock),
      .reset       (reset),
      .update      (accept),
      .raw         (req_tdata[0]),
      .now         (req_tdata[33:2]),
      .debounce_ms (debounce_ff),
      .status      (lane_one)
   );

   tgr_lane u_lane_two (
      .clock       (clock),
      .reset       (reset),
      .update      (accept),
      .raw         (req_tdata[1]),
      .now         (req_tdata[33:2]),
      .debounce_ms (debounce_ff),
      .status      (lane_two)
   );

   tgr_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .update       (accept),
      .lane_one     (lane_one),
      .lane_two     (lane_two),
      .motion_on    (req_tdata[34]),
      .stop_request (req_tdata[35]),
      .travel_speed (speed_ff),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, result.limit_two_stable, result.limit_one_stable,
                        result.speed_cmd, result.toward_limit_two, result.motor_run};

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted update produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   a_stop_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[18:2] == '0))
      else $error("speed nonzero while stopped");

   a_both_limits_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[19] && rsp_tdata[20]) |-> !rsp_tdata[0])
      else $error("motor running with both limits stable");

endmodule
